// ===== src/aals_pkg.sv =====
package aals_pkg;

    // Default geometry of the rasterizer.
    localparam int AALS_COORD_BITS = 12;
    localparam int AALS_FRAC_BITS  = 16;
    localparam int AALS_LEVEL_BITS = 8;

    // Request command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

// ===== src/aals_req_if.sv =====
interface aals_req_if #(
    parameter int COORD_BITS = aals_pkg::AALS_COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] stop_x;
    logic [COORD_BITS-1:0] stop_y;

    modport source (
        output valid, cmd, start_x, start_y, stop_x, stop_y,
        input  ready
    );
    modport sink (
        input  valid, cmd, start_x, start_y, stop_x, stop_y,
        output ready
    );
endinterface

// ===== src/aals_col_if.sv =====
interface aals_col_if #(
    parameter int COORD_BITS = aals_pkg::AALS_COORD_BITS,
    parameter int LEVEL_BITS = aals_pkg::AALS_LEVEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  out_valid;
    logic [COORD_BITS-1:0] near_x;
    logic [COORD_BITS-1:0] near_y;
    logic [LEVEL_BITS-1:0] near_level;
    logic [COORD_BITS:0]   far_x;
    logic [COORD_BITS:0]   far_y;
    logic [LEVEL_BITS-1:0] far_level;
    logic                  last;

    modport source (
        output valid, out_valid, near_x, near_y, near_level,
               far_x, far_y, far_level, last,
        input  ready
    );
    modport sink (
        input  valid, out_valid, near_x, near_y, near_level,
               far_x, far_y, far_level, last,
        output ready
    );
endinterface

// ===== src/aals_div.sv =====
module aals_div #(
    parameter int COORD_BITS = aals_pkg::AALS_COORD_BITS,
    parameter int FRAC_BITS  = aals_pkg::AALS_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [COORD_BITS-1:0] i_num,
    input  logic [COORD_BITS-1:0] i_den,
    output logic                 o_done,
    output logic [FRAC_BITS:0]   o_quot
);
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic                  r_first, n_first;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [COORD_BITS:0]   r_rem, n_rem;
    logic [COORD_BITS-1:0] r_den, n_den;
    logic [FRAC_BITS:0]    r_quot, n_quot;

    logic [COORD_BITS:0]   trial;
    logic                  ge;

    // One restoring compare-subtract step per cycle. The numerator is the
    // dividend followed by FRAC_BITS zeros, so the first step takes the
    // integer bit without shifting and later steps shift in zeros.
    always_comb begin
        trial = r_first ? r_rem : {r_rem[COORD_BITS-1:0], 1'b0};
        ge    = (r_den != '0) && (trial >= {1'b0, r_den});

        n_busy  = r_busy;
        n_done  = 1'b0;
        n_first = r_first;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quot  = r_quot;

        if (i_start) begin
            n_busy  = 1'b1;
            n_first = 1'b1;
            n_cnt   = CNT_W'(FRAC_BITS);
            n_rem   = {1'b0, i_num};
            n_den   = i_den;
            n_quot  = '0;
        end else if (r_busy) begin
            n_first = 1'b0;
            n_rem   = ge ? (trial - {1'b0, r_den}) : trial;
            n_quot  = {r_quot[FRAC_BITS-1:0], ge};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_quot  <= n_quot;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== src/aals_emit.sv =====
module aals_emit #(
    parameter int COORD_BITS = aals_pkg::AALS_COORD_BITS
) (
    input  logic                  i_steep,
    input  logic [COORD_BITS-1:0] i_major,
    input  logic [COORD_BITS-1:0] i_minor,
    output logic [COORD_BITS-1:0] o_near_x,
    output logic [COORD_BITS-1:0] o_near_y,
    output logic [COORD_BITS:0]   o_far_x,
    output logic [COORD_BITS:0]   o_far_y
);
    logic [COORD_BITS:0] minor_up;
    logic [COORD_BITS:0] major_w;

    // The second pixel of a column sits one step further along the minor
    // axis; a steep line maps the minor axis to screen x.
    always_comb begin
        minor_up = {1'b0, i_minor} + 1'b1;
        major_w  = {1'b0, i_major};
        o_near_x = i_steep ? i_minor  : i_major;
        o_near_y = i_steep ? i_major  : i_minor;
        o_far_x  = i_steep ? minor_up : major_w;
        o_far_y  = i_steep ? major_w  : minor_up;
    end
endmodule

// ===== src/antialiased_line_stepper.sv =====
// Channel  Port   Dir  Payload
// -------  -----  ---  ---------------------------------------------------
// request  i_req  in   cmd, start_x, start_y, stop_x, stop_y
// column   o_col  out  out_valid, near_x/y, near_level, far_x/y, far_level,
//                      last
//
// A step request is taken and its column lands in the output register at
// the accept edge, so steps run at one per cycle while o_col drains it. A
// start request keeps the block busy through S_PREP, S_DIVST, S_DIV and
// S_RUN; the bit-serial gradient divider makes one quotient bit per cycle.
// Reset is synchronous and active low; it drops any active line.
// The request side is ready only when idle and when the output register is
// empty or being drained in the same cycle.
module antialiased_line_stepper #(
    parameter int COORD_BITS = aals_pkg::AALS_COORD_BITS,
    parameter int FRAC_BITS  = aals_pkg::AALS_FRAC_BITS,
    parameter int LEVEL_BITS = aals_pkg::AALS_LEVEL_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aals_req_if.sink      i_req,
    aals_col_if.source    o_col
);
    import aals_pkg::*;

    localparam int SLP_W = FRAC_BITS + 2;              // signed Q1.FRAC slope
    localparam int RUN_W = COORD_BITS + FRAC_BITS + 1; // running minor coord
    localparam logic [LEVEL_BITS-1:0] LVL_MAX  = '1;
    localparam logic [LEVEL_BITS-1:0] LVL_HALF = {1'b1, {(LEVEL_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIVST,
        S_DIV,
        S_RUN
    } t_state;

    t_state r_state, n_state;

    // Raw endpoints of a start request.
    logic [COORD_BITS-1:0] r_sx, n_sx, r_sy, n_sy, r_ex, n_ex, r_ey, n_ey;

    // Line state after the axis swap and endpoint ordering.
    logic                  r_steep, n_steep;
    logic [COORD_BITS-1:0] r_x0, n_x0, r_y0, n_y0;
    logic [COORD_BITS-1:0] r_end_major, n_end_major, r_end_minor, n_end_minor;
    logic [COORD_BITS:0]   r_column, n_column;
    logic [RUN_W-1:0]      r_run, n_run;
    logic [SLP_W-1:0]      r_slope, n_slope;
    logic                  r_neg, n_neg;
    logic                  r_active, n_active;
    logic                  r_interior, n_interior;

    // Output register.
    logic                  r_ovld, n_ovld;
    logic                  r_o_out_valid, n_o_out_valid;
    logic [COORD_BITS-1:0] r_o_near_x, n_o_near_x, r_o_near_y, n_o_near_y;
    logic [LEVEL_BITS-1:0] r_o_near_lvl, n_o_near_lvl;
    logic [COORD_BITS:0]   r_o_far_x, n_o_far_x, r_o_far_y, n_o_far_y;
    logic [LEVEL_BITS-1:0] r_o_far_lvl, n_o_far_lvl;
    logic                  r_o_last, n_o_last;

    // Start setup, computed from the raw endpoint registers.
    logic [COORD_BITS-1:0] adx, ady, a0, b0, a1, b1;
    logic [COORD_BITS-1:0] c_x0, c_y0, c_x1, c_y1;
    logic                  c_steep, c_swap;

    // Column forming.
    logic                  req_ready, acc, take, ld, col_zero;
    logic                  sel_steep, sel_last;
    logic [COORD_BITS-1:0] sel_major, sel_minor;
    logic [LEVEL_BITS-1:0] sel_near_lvl, sel_far_lvl, lvl_f;
    logic [FRAC_BITS+LEVEL_BITS-1:0] frac_wide;
    logic [COORD_BITS:0]   column_up;
    logic                  fin_second, fin_inner;
    logic [RUN_W-1:0]      slope_ext, run_base;
    logic [SLP_W-1:0]      quot_ext;

    logic [COORD_BITS-1:0] em_near_x, em_near_y;
    logic [COORD_BITS:0]   em_far_x, em_far_y;

    // Divider interface.
    logic                  div_start, div_done;
    logic [COORD_BITS-1:0] div_num, div_den;
    logic [FRAC_BITS:0]    div_quot;

    aals_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    aals_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .i_steep  (sel_steep),
        .i_major  (sel_major),
        .i_minor  (sel_minor),
        .o_near_x (em_near_x),
        .o_near_y (em_near_y),
        .o_far_x  (em_far_x),
        .o_far_y  (em_far_y)
    );

    // A new request is taken only when idle and the output register is free
    // by the next edge, since a step loads it at the accept edge.
    assign take      = r_ovld && o_col.ready;
    assign req_ready = (r_state == S_IDLE) && (!r_ovld || o_col.ready);
    assign acc       = i_req.valid && req_ready;

    // Setup: the line is steep when it moves further in y than in x. After
    // the possible swap the endpoints are ordered so the major axis rises.
    always_comb begin
        adx     = (r_ex >= r_sx) ? (r_ex - r_sx) : (r_sx - r_ex);
        ady     = (r_ey >= r_sy) ? (r_ey - r_sy) : (r_sy - r_ey);
        c_steep = ady > adx;
        a0      = c_steep ? r_sy : r_sx;
        b0      = c_steep ? r_sx : r_sy;
        a1      = c_steep ? r_ey : r_ex;
        b1      = c_steep ? r_ex : r_ey;
        c_swap  = a0 > a1;
        c_x0    = c_swap ? a1 : a0;
        c_y0    = c_swap ? b1 : b0;
        c_x1    = c_swap ? a0 : a1;
        c_y1    = c_swap ? b0 : b1;
    end

    // The divider works on the ordered endpoints; the slope sign is kept
    // apart and applied when the quotient comes back.
    assign div_num = (r_end_minor >= r_y0) ? (r_end_minor - r_y0) : (r_y0 - r_end_minor);
    assign div_den = r_end_major - r_x0;

    always_comb begin
        // Interior levels come from the top LEVEL_BITS of the fraction.
        frac_wide  = {r_run[FRAC_BITS-1:0], {LEVEL_BITS{1'b0}}} >> FRAC_BITS;
        lvl_f      = frac_wide[LEVEL_BITS-1:0];
        column_up  = r_column + 1'b1;
        fin_second = r_column >= {1'b0, r_end_major};
        fin_inner  = column_up >= {1'b0, r_end_major};
        slope_ext  = {{(RUN_W-SLP_W){r_slope[SLP_W-1]}}, r_slope};
        run_base   = {1'b0, r_y0, {FRAC_BITS{1'b0}}};
        quot_ext   = {1'b0, div_quot};

        n_state     = r_state;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_ex        = r_ex;
        n_ey        = r_ey;
        n_steep     = r_steep;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_end_major = r_end_major;
        n_end_minor = r_end_minor;
        n_column    = r_column;
        n_run       = r_run;
        n_slope     = r_slope;
        n_neg       = r_neg;
        n_active    = r_active;
        n_interior  = r_interior;
        div_start   = 1'b0;

        // By default the emitter sees the next interior column.
        ld           = 1'b0;
        col_zero     = 1'b0;
        sel_steep    = r_steep;
        sel_major    = r_column[COORD_BITS-1:0];
        sel_minor    = r_run[FRAC_BITS +: COORD_BITS];
        sel_near_lvl = LVL_MAX - lvl_f;
        sel_far_lvl  = lvl_f;
        sel_last     = fin_inner;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (i_req.cmd)
                        CMD_START: begin
                            n_sx    = i_req.start_x;
                            n_sy    = i_req.start_y;
                            n_ex    = i_req.stop_x;
                            n_ey    = i_req.stop_y;
                            n_state = S_PREP;
                        end
                        CMD_STEP: begin
                            ld = 1'b1;
                            if (!r_active) begin
                                // Step with no line: an empty column.
                                col_zero = 1'b1;
                            end else if (!r_interior) begin
                                // Second endpoint column.
                                sel_major    = r_end_major;
                                sel_minor    = r_end_minor;
                                sel_near_lvl = LVL_HALF;
                                sel_far_lvl  = '0;
                                sel_last     = fin_second;
                                if (fin_second) begin
                                    n_active = 1'b0;
                                end else begin
                                    n_interior = 1'b1;
                                end
                            end else begin
                                n_column = {1'b0, column_up[COORD_BITS-1:0]};
                                n_run    = r_run + slope_ext;
                                if (fin_inner) begin
                                    n_active   = 1'b0;
                                    n_interior = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end
            S_PREP: begin
                // The first endpoint column goes out now; the output
                // register is known to be empty here.
                ld           = 1'b1;
                sel_steep    = c_steep;
                sel_major    = c_x0;
                sel_minor    = c_y0;
                sel_near_lvl = LVL_HALF;
                sel_far_lvl  = '0;
                sel_last     = 1'b0;
                n_steep      = c_steep;
                n_x0         = c_x0;
                n_y0         = c_y0;
                n_end_major  = c_x1;
                n_end_minor  = c_y1;
                n_column     = {1'b0, c_x0} + 1'b1;
                n_active     = 1'b1;
                n_interior   = 1'b0;
                n_state      = S_DIVST;
            end
            S_DIVST: begin
                div_start = 1'b1;
                n_neg     = r_end_minor < r_y0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_slope = r_neg ? (~quot_ext + 1'b1) : quot_ext;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // Minor coordinate of the first interior column.
                n_run   = run_base + slope_ext;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ovld = ld ? 1'b1 : (take ? 1'b0 : r_ovld);
        if (ld) begin
            n_o_out_valid = !col_zero;
            n_o_near_x    = col_zero ? '0 : em_near_x;
            n_o_near_y    = col_zero ? '0 : em_near_y;
            n_o_near_lvl  = col_zero ? '0 : sel_near_lvl;
            n_o_far_x     = col_zero ? '0 : em_far_x;
            n_o_far_y     = col_zero ? '0 : em_far_y;
            n_o_far_lvl   = col_zero ? '0 : sel_far_lvl;
            n_o_last      = col_zero ? 1'b0 : sel_last;
        end else begin
            n_o_out_valid = r_o_out_valid;
            n_o_near_x    = r_o_near_x;
            n_o_near_y    = r_o_near_y;
            n_o_near_lvl  = r_o_near_lvl;
            n_o_far_x     = r_o_far_x;
            n_o_far_y     = r_o_far_y;
            n_o_far_lvl   = r_o_far_lvl;
            n_o_last      = r_o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx          <= n_sx;
        r_sy          <= n_sy;
        r_ex          <= n_ex;
        r_ey          <= n_ey;
        r_steep       <= n_steep;
        r_x0          <= n_x0;
        r_y0          <= n_y0;
        r_end_major   <= n_end_major;
        r_end_minor   <= n_end_minor;
        r_column      <= n_column;
        r_run         <= n_run;
        r_slope       <= n_slope;
        r_neg         <= n_neg;
        r_o_out_valid <= n_o_out_valid;
        r_o_near_x    <= n_o_near_x;
        r_o_near_y    <= n_o_near_y;
        r_o_near_lvl  <= n_o_near_lvl;
        r_o_far_x     <= n_o_far_x;
        r_o_far_y     <= n_o_far_y;
        r_o_far_lvl   <= n_o_far_lvl;
        r_o_last      <= n_o_last;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= 1'b0;
            r_interior <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_interior <= n_interior;
            r_ovld     <= n_ovld;
        end
    end

    assign i_req.ready      = req_ready;
    assign o_col.valid      = r_ovld;
    assign o_col.out_valid  = r_o_out_valid;
    assign o_col.near_x     = r_o_near_x;
    assign o_col.near_y     = r_o_near_y;
    assign o_col.near_level = r_o_near_lvl;
    assign o_col.far_x      = r_o_far_x;
    assign o_col.far_y      = r_o_far_y;
    assign o_col.far_level  = r_o_far_lvl;
    assign o_col.last       = r_o_last;
endmodule
